// ----- src/bdq_pkg.sv -----
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared constants and types for the bounded deque with linear search.
// ----------------------------------------------------------------------------
package bdq_pkg;

   localparam int DEPTH   = 16;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int WORD_W  = 32;
   localparam int ACT_W   = 3;
   localparam int STAT_W  = 2;
   localparam int POS_W   = 5;

   typedef enum logic [ACT_W-1:0] {
      ACT_PUSH_FRONT = 3'd0,
      ACT_PUSH_BACK  = 3'd1,
      ACT_POP_FRONT  = 3'd2,
      ACT_POP_BACK   = 3'd3,
      ACT_SEARCH     = 3'd4
   } act_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_PUSH_FRONT,
      CELL_PUSH_BACK,
      CELL_POP_FRONT
   } cell_op_type;

   typedef enum logic {
      FSM_IDLE,
      FSM_SEARCH
   } fsm_type;

   typedef struct packed {
      cell_op_type      op;
      logic [CNT_W-1:0] count;
      logic             probe_clear;
   } cell_ctrl_type;

endpackage

// ----- src/bdq_cell.sv -----
// ----------------------------------------------------------------------------
// bdq_cell
// One slot of the deque chain: holds a word, shifts it to a neighbor on
// front pushes and pops, and compares it against the search key under the probe.
// ----------------------------------------------------------------------------
module bdq_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  bdq_pkg::cell_ctrl_type       ctrl,
   input  logic [bdq_pkg::CNT_W-1:0]    cell_index,
   input  logic [bdq_pkg::WORD_W-1:0]   value,
   input  logic [bdq_pkg::WORD_W-1:0]   left_data,
   input  logic [bdq_pkg::WORD_W-1:0]   right_data,
   input  logic                         probe_in,
   input  logic [bdq_pkg::WORD_W-1:0]   key,
   output logic [bdq_pkg::WORD_W-1:0]   data,
   output logic [bdq_pkg::WORD_W-1:0]   tail_data,
   output logic                         probe_out,
   output logic                         hit
);
   import bdq_pkg::*;

   logic [WORD_W-1:0] data_ff;
   logic [WORD_W-1:0] data_in;
   logic              probe_ff;
   logic              probe_next;
   logic              is_last;

   always_comb begin
      data_in = data_ff;
      unique case (ctrl.op)
         CELL_HOLD:       data_in = data_ff;
         CELL_PUSH_FRONT: data_in = left_data;
         CELL_PUSH_BACK: begin
            if (cell_index == ctrl.count) data_in = value;
         end
         CELL_POP_FRONT:  data_in = right_data;
         default:         data_in = data_ff;
      endcase
   end

   // advance the probe one slot a cycle unless the search is done
   assign probe_next = ctrl.probe_clear ? 1'b0 : probe_in;

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= 1'b0;
      end else begin
         probe_ff <= probe_next;
      end
   end

   assign is_last   = (ctrl.count == cell_index + CNT_W'(1));
   assign data      = data_ff;
   assign tail_data = is_last ? data_ff : '0;
   assign probe_out = probe_ff;
   assign hit       = probe_ff && (data_ff == key);

endmodule

// ----- src/bounded_deque_with_search_core.sv -----
// ----------------------------------------------------------------------------
// bounded_deque_with_search_core
// Bounded double-ended queue of 32-bit words with a front-to-back search.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_ (action, value) with valid/stall; one result per
//   request leaves on rsp_ (status, popped, position, occupancy).
//   Entries sit in a chain of DEPTH cells ordered from front to back; a
//   front push or pop shifts the whole chain by one slot.
//   Push, pop and unused actions: result registered in the cycle after the
//   transfer, one request per cycle while the result side keeps up.
//   Search: a probe walks the chain one cell per cycle and stops at a hit
//   or at the last occupied cell; an empty queue gives not found with no
//   walk; no request is taken while the probe walks.
//   A result held by rsp_stall holds the register; a new request is taken
//   only when that register is free or drains in the same cycle.
//   Reset clears the occupancy, the probes and the result valid flag; the
//   stored words are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [2:0]                  req_action,
   input  logic signed [31:0]          req_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_status,
   output logic signed [31:0]          rsp_popped,
   output logic [4:0]                  rsp_position,
   output logic [4:0]                  rsp_occupancy
);
   import bdq_pkg::*;

   fsm_type            state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   step_ff, step_in;
   logic [WORD_W-1:0]  key_ff, key_in;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [WORD_W-1:0]  rsp_popped_ff, rsp_popped_in;
   logic [POS_W-1:0]   rsp_position_ff, rsp_position_in;
   logic [POS_W-1:0]   rsp_occupancy_ff, rsp_occupancy_in;

   cell_ctrl_type      ctrl;
   logic               accept;
   logic               rsp_taken;
   logic               launch;
   logic               any_hit;
   logic               last_step;
   logic [WORD_W-1:0]  tail_word;

   logic [WORD_W-1:0]  cell_data [DEPTH];
   logic [WORD_W-1:0]  cell_tail [DEPTH];
   logic [WORD_W-1:0]  cell_left [DEPTH];
   logic [WORD_W-1:0]  cell_right [DEPTH];
   logic [DEPTH-1:0]   cell_probe_in;
   logic [DEPTH-1:0]   cell_probe;
   logic [DEPTH-1:0]   cell_hit;

   assign rsp_taken = rsp_valid_ff && !rsp_stall;
   assign req_stall = (state_ff != FSM_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         if (g == 0) begin : g_head
            assign cell_left[g]     = req_value;
            assign cell_probe_in[g] = launch;
         end else begin : g_body
            assign cell_left[g]     = cell_data[g-1];
            assign cell_probe_in[g] = cell_probe[g-1];
         end
         if (g == DEPTH - 1) begin : g_tail
            assign cell_right[g] = '0;
         end else begin : g_inner
            assign cell_right[g] = cell_data[g+1];
         end

         bdq_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .cell_index (CNT_W'(g)),
            .value      (req_value),
            .left_data  (cell_left[g]),
            .right_data (cell_right[g]),
            .probe_in   (cell_probe_in[g]),
            .key        (key_ff),
            .data       (cell_data[g]),
            .tail_data  (cell_tail[g]),
            .probe_out  (cell_probe[g]),
            .hit        (cell_hit[g])
         );
      end
   endgenerate

   always_comb begin
      tail_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         tail_word = tail_word | cell_tail[i];
      end
   end

   assign any_hit   = |cell_hit;
   assign last_step = ((CNT_W'(step_ff) + CNT_W'(1)) == count_ff);

   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      step_in          = step_ff;
      key_in           = key_ff;
      launch           = 1'b0;
      ctrl.op          = CELL_HOLD;
      ctrl.count       = count_ff;
      ctrl.probe_clear = 1'b0;
      rsp_valid_in     = rsp_taken ? 1'b0 : rsp_valid_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_popped_in    = rsp_popped_ff;
      rsp_position_in  = rsp_position_ff;
      rsp_occupancy_in = rsp_occupancy_ff;

      unique case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = STAT_OK;
               rsp_popped_in   = '0;
               rsp_position_in = '0;
               unique case (act_type'(req_action))
                  ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                     if (count_ff == CNT_W'(DEPTH)) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        ctrl.op  = (act_type'(req_action) == ACT_PUSH_FRONT) ?
                                   CELL_PUSH_FRONT : CELL_PUSH_BACK;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  ACT_POP_FRONT: begin
                     if (count_ff == '0) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        ctrl.op       = CELL_POP_FRONT;
                        rsp_popped_in = cell_data[0];
                        count_in      = count_ff - CNT_W'(1);
                     end
                  end
                  ACT_POP_BACK: begin
                     if (count_ff == '0) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        rsp_popped_in = tail_word;
                        count_in      = count_ff - CNT_W'(1);
                     end
                  end
                  ACT_SEARCH: begin
                     if (count_ff == '0) begin
                        rsp_status_in = STAT_NOT_FOUND;
                     end else begin
                        // hold the result until the probe finishes its walk
                        rsp_valid_in = 1'b0;
                        launch       = 1'b1;
                        key_in       = req_value;
                        step_in      = '0;
                        state_in     = FSM_SEARCH;
                     end
                  end
                  default: ;
               endcase
               rsp_occupancy_in = POS_W'(count_in);
            end
         end
         FSM_SEARCH: begin
            if (any_hit || last_step) begin
               ctrl.probe_clear = 1'b1;
               rsp_valid_in     = 1'b1;
               rsp_popped_in    = '0;
               rsp_occupancy_in = POS_W'(count_ff);
               rsp_status_in    = any_hit ? STAT_OK : STAT_NOT_FOUND;
               rsp_position_in  = any_hit ? (POS_W'(step_ff) + POS_W'(1)) : '0;
               state_in         = FSM_IDLE;
            end else begin
               step_in = step_ff + IDX_W'(1);
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff          <= step_in;
      key_ff           <= key_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_popped_ff    <= rsp_popped_in;
      rsp_position_ff  <= rsp_position_in;
      rsp_occupancy_ff <= rsp_occupancy_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_popped    = rsp_popped_ff;
   assign rsp_position  = rsp_position_ff;
   assign rsp_occupancy = rsp_occupancy_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("occupancy exceeds depth");

   a_single_probe: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cell_probe))
      else $error("more than one search probe in the chain");

   a_search_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_SEARCH) |-> !rsp_valid_ff)
      else $error("result pending while a search walks");

   a_direct_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && !launch) |=> rsp_valid_ff)
      else $error("non-search request produced no result");
`endif

endmodule
